[rtl/core/dpv_pkg.sv]
// shared types, constants and helper functions of the delta prefix varint decoder
package dpv_pkg;

   localparam int unsigned VALUE_W = 64;
   localparam int unsigned COUNT_W = 31;
   localparam int unsigned INDEX_W = 3;
   localparam int unsigned BODY_CNT_W = 7;
   localparam int unsigned ONES_W = 3;

   localparam logic [ONES_W-1:0] PREFIX_MAX = 3'd4;

   // body widths selected by the number of leading ones of the prefix
   localparam logic [BODY_CNT_W-1:0] NARROW_WIDTH [5] = '{7'd0, 7'd6, 7'd9, 7'd12, 7'd32};
   localparam logic [BODY_CNT_W-1:0] WIDE_WIDTH [5] = '{7'd0, 7'd6, 7'd13, 7'd20, 7'd64};

   typedef enum logic [INDEX_W-1:0] {
      CSR_WIDE_MODE      = 3'd0,
      CSR_BASE_VALUE     = 3'd1,
      CSR_AUTO_INCREMENT = 3'd2,
      CSR_SEARCH_KEY     = 3'd3,
      CSR_VALUE_COUNT    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_WAIT   = 2'd0,
      PH_PREFIX = 2'd1,
      PH_BODY   = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef struct packed {
      logic               wide_mode;
      logic [VALUE_W-1:0] base_value;
      logic [VALUE_W-1:0] auto_increment;
      logic [VALUE_W-1:0] search_key;
      logic [COUNT_W-1:0] value_count;
   } cfg_type;

   typedef struct packed {
      logic               emit;
      logic               start;
      logic               wide;
      logic [VALUE_W-1:0] delta;
   } dec_type;

   typedef struct packed {
      logic [VALUE_W-1:0] decoded_value;
      logic [COUNT_W-1:0] value_index;
      logic               final_value;
      logic               key_hit;
      logic               key_seen;
      logic [COUNT_W-1:0] key_position;
   } res_type;

   function automatic logic [BODY_CNT_W-1:0] width_of(input logic wide,
                                                      input logic [ONES_W-1:0] ones);
      logic [ONES_W-1:0] k;
      k = (ones > PREFIX_MAX) ? PREFIX_MAX : ones;
      return wide ? WIDE_WIDTH[k] : NARROW_WIDTH[k];
   endfunction

   function automatic logic [VALUE_W-1:0] sext32(input logic [VALUE_W-1:0] x);
      return {{32{x[31]}}, x[31:0]};
   endfunction

   // short bodies above half range wrap to negative, which is a sign extension
   function automatic logic [VALUE_W-1:0] fold_body(input logic [VALUE_W-1:0] body,
                                                    input logic wide,
                                                    input logic [ONES_W-1:0] ones);
      logic [BODY_CNT_W-1:0] w;
      logic [VALUE_W-1:0]    hi;
      logic [VALUE_W-1:0]    msk;
      logic                  neg;
      w   = width_of(wide, ones);
      hi  = 64'd1 << (w - 7'd1);
      msk = (hi << 1) - 64'd1;
      neg = (|(body & hi)) && (|(body & (hi - 64'd1)));
      if (w == 7'd64) begin
         return body;
      end else if (w == 7'd32) begin
         return sext32(body);
      end else if (w == 7'd0) begin
         return '0;
      end else begin
         return neg ? (body | ~msk) : (body & msk);
      end
   endfunction

endpackage

[rtl/core/dpv_if.sv]
// valid/ready channel interfaces for bits in, values out and register writes

interface dpv_req_if;
   logic valid;
   logic ready;
   logic code_bit;
   logic block_start;

   modport source (output valid, output code_bit, output block_start, input ready);
   modport sink (input valid, input code_bit, input block_start, output ready);
endinterface

interface dpv_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [63:0] decoded_value;
   logic [30:0] value_index;
   logic        final_value;
   logic        key_hit;
   logic        key_seen;
   logic [30:0] key_position;

   modport source (output valid, output decoded_value, output value_index,
                   output final_value, output key_hit, output key_seen,
                   output key_position, input ready);
   modport sink (input valid, input decoded_value, input value_index,
                 input final_value, input key_hit, input key_seen,
                 input key_position, output ready);
endinterface

interface dpv_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/dpv_csr.sv]
// configuration registers written through the csr channel
module dpv_csr (
   input  logic             clock,
   input  logic             reset,
   dpv_csr_if.sink          csr_chan,
   output dpv_pkg::cfg_type cfg
);

   dpv_pkg::cfg_type cfg_ff;
   dpv_pkg::cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (dpv_pkg::csr_index_type'(csr_chan.index))
            dpv_pkg::CSR_WIDE_MODE:      cfg_in.wide_mode = csr_chan.data[0];
            dpv_pkg::CSR_BASE_VALUE:     cfg_in.base_value = csr_chan.data;
            dpv_pkg::CSR_AUTO_INCREMENT: cfg_in.auto_increment = csr_chan.data;
            dpv_pkg::CSR_SEARCH_KEY:     cfg_in.search_key = csr_chan.data;
            dpv_pkg::CSR_VALUE_COUNT:    cfg_in.value_count = csr_chan.data[30:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wide_mode      <= 1'b0;
         cfg_ff.base_value     <= '0;
         cfg_ff.auto_increment <= '0;
         cfg_ff.search_key     <= '0;
         cfg_ff.value_count    <= 31'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/core/dpv_bit_decoder.sv]
// prefix and body bit parser: one coded bit per step, yields the folded delta
module dpv_bit_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic             code_bit,
   input  logic             block_start,
   input  logic             cfg_wide,
   input  logic             last_value,
   output dpv_pkg::dec_type dec
);

   dpv_pkg::phase_type                 phase_ff, phase_in, ph;
   logic [dpv_pkg::ONES_W-1:0]         ones_ff, ones_in, ones, ones_inc;
   logic [dpv_pkg::VALUE_W-1:0]        shift_ff, shift_in, shift, shift_nx;
   logic [dpv_pkg::BODY_CNT_W-1:0]     left_ff, left_in, left, left_dec;
   logic                               wide_ff, wide_in, wide;
   logic                               emit;

   // a block start restarts the parse on this very bit
   always_comb begin
      ph       = block_start ? dpv_pkg::PH_PREFIX : phase_ff;
      ones     = block_start ? '0 : ones_ff;
      shift    = block_start ? '0 : shift_ff;
      left     = block_start ? '0 : left_ff;
      wide     = block_start ? cfg_wide : wide_ff;
      ones_inc = ones + 3'd1;
      shift_nx = {shift[dpv_pkg::VALUE_W-2:0], code_bit};
      left_dec = (left != '0) ? left - 7'd1 : '0;
   end

   // outputs
   always_comb begin
      emit = 1'b0;
      unique case (ph)
         dpv_pkg::PH_PREFIX: emit = !code_bit && (ones == '0);
         dpv_pkg::PH_BODY:   emit = (left_dec == '0);
         dpv_pkg::PH_WAIT,
         dpv_pkg::PH_DONE:   emit = 1'b0;
         default:            emit = 1'b0;
      endcase
      dec.emit  = emit;
      dec.start = block_start;
      dec.wide  = wide;
      dec.delta = (ph == dpv_pkg::PH_BODY) ? dpv_pkg::fold_body(shift_nx, wide, ones) : '0;
   end

   // next state
   always_comb begin
      phase_in = ph;
      ones_in  = ones;
      shift_in = shift;
      left_in  = left;
      wide_in  = wide;
      unique case (ph)
         dpv_pkg::PH_PREFIX: begin
            if (code_bit) begin
               if (ones_inc >= dpv_pkg::PREFIX_MAX) begin
                  ones_in  = dpv_pkg::PREFIX_MAX;
                  shift_in = '0;
                  left_in  = dpv_pkg::width_of(wide, dpv_pkg::PREFIX_MAX);
                  phase_in = dpv_pkg::PH_BODY;
               end else begin
                  ones_in = ones_inc;
               end
            end else if (ones != '0) begin
               shift_in = '0;
               left_in  = dpv_pkg::width_of(wide, ones);
               phase_in = dpv_pkg::PH_BODY;
            end
         end
         dpv_pkg::PH_BODY: begin
            shift_in = shift_nx;
            left_in  = left_dec;
         end
         dpv_pkg::PH_WAIT,
         dpv_pkg::PH_DONE: begin
         end
         default: begin
         end
      endcase
      if (emit) begin
         phase_in = last_value ? dpv_pkg::PH_DONE : dpv_pkg::PH_PREFIX;
         ones_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dpv_pkg::PH_WAIT;
         ones_ff  <= '0;
         left_ff  <= '0;
         wide_ff  <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         ones_ff  <= ones_in;
         left_ff  <= left_in;
         wide_ff  <= wide_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         shift_ff <= shift_in;
      end
   end

`ifndef SYNTH
   a_body_has_bits: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == dpv_pkg::PH_BODY) |-> (left_ff != '0))
      else $error("body phase with no bits left");

   a_prefix_bound: assert property (@(posedge clock) disable iff (reset)
      ones_ff <= dpv_pkg::PREFIX_MAX)
      else $error("prefix count beyond four");

   a_last_ends_block: assert property (@(posedge clock) disable iff (reset)
      (step && emit && last_value) |=> (phase_ff == dpv_pkg::PH_DONE))
      else $error("last value did not close the block");
`endif

endmodule

[rtl/core/dpv_value_acc.sv]
// running value, index count and key match tracking
module dpv_value_acc (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  dpv_pkg::dec_type dec,
   input  dpv_pkg::cfg_type cfg,
   output dpv_pkg::res_type res
);

   logic [dpv_pkg::VALUE_W-1:0] prev_ff, prev_in;
   logic [dpv_pkg::COUNT_W-1:0] done_ff, done_in;
   logic                        flag_ff, flag_in;
   logic [dpv_pkg::COUNT_W-1:0] pos_ff, pos_in;

   logic [dpv_pkg::VALUE_W-1:0] sum;
   logic [dpv_pkg::VALUE_W-1:0] raw;
   logic [dpv_pkg::VALUE_W-1:0] value;
   logic [dpv_pkg::COUNT_W-1:0] idx;
   logic [dpv_pkg::COUNT_W:0]   idx_nx;
   logic                        last;
   logic                        hit;
   logic                        flag_nx;
   logic [dpv_pkg::COUNT_W-1:0] pos_nx;

   always_comb begin
      sum   = dec.delta + prev_ff + cfg.auto_increment;
      // a value on the start bit has a zero delta, so it is the base itself
      raw   = dec.start ? cfg.base_value : sum;
      value = dec.wide ? raw : dpv_pkg::sext32(raw);
      idx   = dec.start ? '0 : done_ff;
      idx_nx = {1'b0, idx} + 32'd1;
      last  = idx_nx >= {1'b0, cfg.value_count};
      hit   = (value == cfg.search_key);
      flag_nx = (dec.start ? 1'b0 : flag_ff) | hit;
      pos_nx  = hit ? idx : (dec.start ? '0 : pos_ff);

      res.decoded_value = value;
      res.value_index   = idx;
      res.final_value   = last;
      res.key_hit       = hit;
      res.key_seen      = flag_nx;
      res.key_position  = flag_nx ? pos_nx : '0;

      prev_in = prev_ff;
      done_in = done_ff;
      flag_in = flag_ff;
      pos_in  = pos_ff;
      if (dec.emit) begin
         prev_in = value;
         done_in = idx_nx[dpv_pkg::COUNT_W-1:0];
         flag_in = flag_nx;
         pos_in  = pos_nx;
      end else if (dec.start) begin
         prev_in = cfg.base_value - cfg.auto_increment;
         done_in = '0;
         flag_in = 1'b0;
         pos_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= '0;
         flag_ff <= 1'b0;
         pos_ff  <= '0;
      end else if (step) begin
         done_ff <= done_in;
         flag_ff <= flag_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         prev_ff <= prev_in;
      end
   end

endmodule

[rtl/core/delta_prefix_varint_decoder.sv]
// top level of the delta prefix varint decoder
//
// req_chan carries one coded bit per item, most significant bit of each field
// first; block_start marks the first bit of a block and restarts decoding.
// rsp_chan carries one item for each bit that completes a value: the value,
// its index in the block, a last-value flag and the key match status.
// csr_chan writes the registers (wide mode, base, auto increment, search key,
// value count); it is always ready and takes one write per cycle.
// Each bit goes through an input register and the decode logic, and a
// finished value lands in the output register, which offers it on rsp_chan.
// One bit is taken every cycle unless a bit that finishes a value is held
// back by a stalled rsp_chan.
// Reset restores the register defaults and the decoder waits for a block
// start; bits before it, and after the last value of a block, are dropped.
// When rsp_chan stalls, bits that finish no value keep flowing; a bit that
// finishes one waits in the input register and req_chan.ready drops.
module delta_prefix_varint_decoder (
   input  logic      clock,
   input  logic      reset,
   dpv_req_if.sink   req_chan,
   dpv_rsp_if.source rsp_chan,
   dpv_csr_if.sink   csr_chan
);

   dpv_pkg::cfg_type cfg;
   dpv_pkg::dec_type dec;
   dpv_pkg::res_type res;
   dpv_pkg::res_type rsp_ff;

   logic s1_valid_ff, s1_valid_in;
   logic s1_bit_ff;
   logic s1_start_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic step;
   logic req_take;

   dpv_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   dpv_bit_decoder u_dec (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .code_bit    (s1_bit_ff),
      .block_start (s1_start_ff),
      .cfg_wide    (cfg.wide_mode),
      .last_value  (res.final_value),
      .dec         (dec)
   );

   dpv_value_acc u_acc (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .dec   (dec),
      .cfg   (cfg),
      .res   (res)
   );

   // only a bit that finishes a value needs room in the output register
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign step     = s1_valid_ff && (!dec.emit || out_free);
   assign req_chan.ready = !s1_valid_ff || step;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step && dec.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_bit_ff   <= req_chan.code_bit;
         s1_start_ff <= req_chan.block_start;
      end
      if (step && dec.emit) begin
         rsp_ff <= res;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.decoded_value = rsp_ff.decoded_value;
   assign rsp_chan.value_index   = rsp_ff.value_index;
   assign rsp_chan.final_value   = rsp_ff.final_value;
   assign rsp_chan.key_hit       = rsp_ff.key_hit;
   assign rsp_chan.key_seen      = rsp_ff.key_seen;
   assign rsp_chan.key_position  = rsp_ff.key_position;

`ifndef SYNTH
   a_value_reaches_output: assert property (@(posedge clock) disable iff (reset)
      (step && dec.emit) |=> rsp_valid_ff)
      else $error("finished value not loaded into output register");

   a_held_item_kept: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !step) |=> s1_valid_ff)
      else $error("stalled item dropped from input register");
`endif

endmodule
